[rtl/pwhd_pkg.sv]
// ----------------------------------------------------------------------------
// pwhd_pkg
// Shared types, constants and lookup functions for the peer wire handshake
// deframer: phase codes, event and error codes, result and config bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package pwhd_pkg;

  // Handshake layout
  localparam int unsigned HASH_BYTES    = 20;
  localparam int unsigned PEER_ID_BYTES = 20;
  localparam int unsigned HS_TEXT_LEN   = 19;
  localparam int unsigned HS_HASH_FIRST = 28;
  localparam int unsigned HS_PEER_FIRST = HS_HASH_FIRST + HASH_BYTES;
  localparam int unsigned HS_LAST       = HS_PEER_FIRST + PEER_ID_BYTES - 1;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned PLEN_W   = 20;
  localparam int unsigned CAP_W    = 21;
  localparam int unsigned HASH_W   = HASH_BYTES * BYTE_W;
  localparam int unsigned CFG_DW   = 64;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned M_TDATA_W = 32;

  // Length cap ceiling and register reset
  localparam logic [CAP_W-1:0] LENGTH_CEILING = CAP_W'(1 << 20);

  // Configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_HASH_HIGH = 2'd0,
    CFG_HASH_MID  = 2'd1,
    CFG_HASH_LOW  = 2'd2,
    CFG_MAX_LEN   = 2'd3
  } cfg_idx_e;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HANDSHAKE = 5'b00001,
    PH_LENGTH    = 5'b00010,
    PH_ID        = 5'b00100,
    PH_PAYLOAD   = 5'b01000,
    PH_ERROR     = 5'b10000
  } phase_e;

  // Result event kinds
  typedef enum logic [2:0] {
    EV_CONSUMED  = 3'd0,
    EV_HS_OK     = 3'd1,
    EV_KEEPALIVE = 3'd2,
    EV_MSG_ID    = 3'd3,
    EV_PAYLOAD   = 3'd4,
    EV_ERROR     = 3'd5,
    EV_PEER_ID   = 3'd6
  } event_e;

  // Error codes
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_PROTOCOL = 2'd1,
    ERR_HASH     = 2'd2,
    ERR_OVERSIZE = 2'd3
  } err_e;

  // Configuration bundle
  typedef struct packed {
    logic [HASH_W-1:0] expected_hash;   // hash byte 0 in the top byte
    logic [CAP_W-1:0]  max_message_length;
  } cfg_t;

  // One result item
  typedef struct packed {
    event_e             event_kind;
    logic [BYTE_W-1:0]  data;
    logic [PLEN_W-1:0]  payload_length;
    logic               last;
    err_e               error_code;
  } result_t;

  // Expected protocol string character, index 0..18
  function automatic logic [BYTE_W-1:0] proto_char(input logic [4:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      5'd0:    c = 8'h42; // B
      5'd1:    c = 8'h69; // i
      5'd2:    c = 8'h74; // t
      5'd3:    c = 8'h54; // T
      5'd4:    c = 8'h6f; // o
      5'd5:    c = 8'h72; // r
      5'd6:    c = 8'h72; // r
      5'd7:    c = 8'h65; // e
      5'd8:    c = 8'h6e; // n
      5'd9:    c = 8'h74; // t
      5'd10:   c = 8'h20; // space
      5'd11:   c = 8'h70; // p
      5'd12:   c = 8'h72; // r
      5'd13:   c = 8'h6f; // o
      5'd14:   c = 8'h74; // t
      5'd15:   c = 8'h6f; // o
      5'd16:   c = 8'h63; // c
      5'd17:   c = 8'h6f; // o
      5'd18:   c = 8'h6c; // l
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/pwhd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// pwhd_cfg_regs
// Configuration register file: expected info hash and message length cap.
// ----------------------------------------------------------------------------
`default_nettype none

module pwhd_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wr_en_i,
  input  wire logic [pwhd_pkg::CFG_IW-1:0] wr_index_i,
  input  wire logic [pwhd_pkg::CFG_DW-1:0] wr_data_i,
  output pwhd_pkg::cfg_t                  cfg_o
);
  import pwhd_pkg::*;

  logic [63:0]      hash_high_q;
  logic [63:0]      hash_mid_q;
  logic [31:0]      hash_low_q;
  logic [CAP_W-1:0] max_len_q;

  // Register writes; indexes outside the list do not exist with a 2-bit index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_high_q <= '0;
      hash_mid_q  <= '0;
      hash_low_q  <= '0;
      max_len_q   <= LENGTH_CEILING;
    end else if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_HASH_HIGH: hash_high_q <= wr_data_i;
        CFG_HASH_MID:  hash_mid_q  <= wr_data_i;
        CFG_HASH_LOW:  hash_low_q  <= wr_data_i[31:0];
        CFG_MAX_LEN:   max_len_q   <= wr_data_i[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.expected_hash      = {hash_high_q, hash_mid_q, hash_low_q};
  assign cfg_o.max_message_length = max_len_q;

endmodule

`default_nettype wire

[rtl/pwhd_parser.sv]
// ----------------------------------------------------------------------------
// pwhd_parser
// Parser state and single-pass next-state/result logic for one stream byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pwhd_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,     // consume the held byte
  input  wire logic [pwhd_pkg::BYTE_W-1:0] rx_byte_i,
  input  wire logic                       restart_i,
  input  pwhd_pkg::cfg_t                  cfg_i,
  output pwhd_pkg::result_t               res_o
);
  import pwhd_pkg::*;

  phase_e            phase_q,      phase_d;
  logic [POS_W-1:0]  byte_pos_q,   byte_pos_d;
  logic [LEN_W-1:0]  len_shift_q,  len_shift_d;
  logic [PLEN_W-1:0] remaining_q,  remaining_d;
  logic              proto_bad_q,  proto_bad_d;
  logic              hash_bad_q,   hash_bad_d;
  err_e              sticky_err_q, sticky_err_d;

  logic [BYTE_W-1:0] hash_b [HASH_BYTES];
  logic [4:0]        hash_k;
  logic [4:0]        text_k;
  logic [BYTE_W-1:0] exp_hash;
  logic [LEN_W-1:0]  len_new;
  logic [CAP_W-1:0]  cap;
  logic [PLEN_W-1:0] rem_dec;
  logic              hs_bad;

  // Expected hash bytes, byte 0 from the top of the vector
  always_comb begin
    for (int k = 0; k < HASH_BYTES; k++) begin
      hash_b[k] = cfg_i.expected_hash[HASH_W-1-k*BYTE_W -: BYTE_W];
    end
  end

  assign hash_k   = 5'(byte_pos_q - POS_W'(HS_HASH_FIRST));
  assign text_k   = 5'(byte_pos_q - POS_W'(1));
  assign exp_hash = (hash_k < 5'(HASH_BYTES)) ? hash_b[hash_k] : '0;
  assign len_new  = {len_shift_q[LEN_W-BYTE_W-1:0], rx_byte_i};
  assign cap      = (cfg_i.max_message_length > LENGTH_CEILING) ? LENGTH_CEILING
                                                                 : cfg_i.max_message_length;
  assign rem_dec  = (remaining_q != '0) ? remaining_q - PLEN_W'(1) : remaining_q;
  assign hs_bad   = proto_bad_d | hash_bad_d;

  // Next state and result
  always_comb begin
    phase_d      = phase_q;
    byte_pos_d   = byte_pos_q;
    len_shift_d  = len_shift_q;
    remaining_d  = remaining_q;
    proto_bad_d  = proto_bad_q;
    hash_bad_d   = hash_bad_q;
    sticky_err_d = sticky_err_q;
    res_o        = '{event_kind: EV_CONSUMED, data: '0, payload_length: '0,
                     last: 1'b0, error_code: ERR_NONE};

    if (restart_i) begin
      phase_d      = PH_HANDSHAKE;
      byte_pos_d   = '0;
      len_shift_d  = '0;
      remaining_d  = '0;
      proto_bad_d  = 1'b0;
      hash_bad_d   = 1'b0;
      sticky_err_d = ERR_NONE;
    end else begin
      case (phase_q)
        PH_HANDSHAKE: begin
          // protocol string and info hash checks
          if (byte_pos_q == '0) begin
            if (rx_byte_i != BYTE_W'(HS_TEXT_LEN)) proto_bad_d = 1'b1;
          end else if (byte_pos_q <= POS_W'(HS_TEXT_LEN)) begin
            if (rx_byte_i != proto_char(text_k)) proto_bad_d = 1'b1;
          end else if (byte_pos_q >= POS_W'(HS_HASH_FIRST) &&
                       byte_pos_q <  POS_W'(HS_PEER_FIRST)) begin
            if (rx_byte_i != exp_hash) hash_bad_d = 1'b1;
          end
          if (byte_pos_q >= POS_W'(HS_LAST)) begin
            // verdict on the last handshake byte
            byte_pos_d = '0;
            if (hs_bad) begin
              sticky_err_d     = proto_bad_d ? ERR_PROTOCOL : ERR_HASH;
              phase_d          = PH_ERROR;
              res_o.event_kind = EV_ERROR;
              res_o.error_code = proto_bad_d ? ERR_PROTOCOL : ERR_HASH;
            end else begin
              phase_d          = PH_LENGTH;
              len_shift_d      = '0;
              res_o.event_kind = EV_HS_OK;
              res_o.data       = rx_byte_i;
            end
          end else begin
            byte_pos_d = byte_pos_q + POS_W'(1);
            if (byte_pos_q >= POS_W'(HS_PEER_FIRST) && !hs_bad) begin
              res_o.event_kind = EV_PEER_ID;
              res_o.data       = rx_byte_i;
            end
          end
        end

        PH_LENGTH: begin
          // big-endian length, verdict on the fourth byte
          if (byte_pos_q[1:0] != 2'd3) begin
            len_shift_d = len_new;
            byte_pos_d  = {{(POS_W-2){1'b0}}, byte_pos_q[1:0] + 2'd1};
          end else begin
            byte_pos_d  = '0;
            len_shift_d = '0;
            if (len_new == '0) begin
              res_o.event_kind = EV_KEEPALIVE;
            end else if (len_new > LEN_W'(cap)) begin
              sticky_err_d     = ERR_OVERSIZE;
              phase_d          = PH_ERROR;
              res_o.event_kind = EV_ERROR;
              res_o.error_code = ERR_OVERSIZE;
            end else begin
              remaining_d = PLEN_W'(len_new - LEN_W'(1));
              phase_d     = PH_ID;
            end
          end
        end

        PH_ID: begin
          res_o.event_kind = EV_MSG_ID;
          res_o.data       = rx_byte_i;
          if (remaining_q == '0) begin
            phase_d    = PH_LENGTH;
            res_o.last = 1'b1;
          end else begin
            phase_d              = PH_PAYLOAD;
            res_o.payload_length = remaining_q;
          end
        end

        PH_PAYLOAD: begin
          remaining_d      = rem_dec;
          res_o.event_kind = EV_PAYLOAD;
          res_o.data       = rx_byte_i;
          if (rem_dec == '0) begin
            phase_d    = PH_LENGTH;
            byte_pos_d = '0;
            res_o.last = 1'b1;
          end
        end

        default: begin
          // sticky error until restart
          phase_d          = PH_ERROR;
          res_o.event_kind = EV_ERROR;
          res_o.error_code = sticky_err_q;
        end
      endcase
    end
  end

  // State registers advance once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HANDSHAKE;
      byte_pos_q   <= '0;
      len_shift_q  <= '0;
      remaining_q  <= '0;
      proto_bad_q  <= 1'b0;
      hash_bad_q   <= 1'b0;
      sticky_err_q <= ERR_NONE;
    end else if (step_i) begin
      phase_q      <= phase_d;
      byte_pos_q   <= byte_pos_d;
      len_shift_q  <= len_shift_d;
      remaining_q  <= remaining_d;
      proto_bad_q  <= proto_bad_d;
      hash_bad_q   <= hash_bad_d;
      sticky_err_q <= sticky_err_d;
    end
  end

endmodule

`default_nettype wire

[rtl/pwhd_out_reg.sv]
// ----------------------------------------------------------------------------
// pwhd_out_reg
// Result register on the master side; holds a result until its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module pwhd_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  pwhd_pkg::result_t  res_i,
  output logic               free_o,   // can take a result this cycle
  output logic               valid_o,
  input  wire logic          ready_i,
  output pwhd_pkg::result_t  res_o
);
  import pwhd_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

[rtl/peer_wire_handshake_deframer_core.sv]
// ----------------------------------------------------------------------------
// peer_wire_handshake_deframer_core
// Peer wire handshake checker and length-prefixed message deframer.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries the received connection stream, one byte per transfer in
//   tdata; tuser = 1 marks a restart item that clears all parse state and
//   whose byte is ignored. Every input transfer produces exactly one result
//   transfer on m_axis: event kind in tuser, end of message in tlast, and
//   data byte, payload length and error code packed in tdata.
//   The cfg channel writes the expected info hash (indexes 0..2) and the
//   message length cap (index 3); write it only while the block is idle.
//   Throughput is one byte per cycle while m_axis takes every result. A byte
//   is captured in the input register, and its result is written to the
//   result register once that register is free to take it.
//   When m_axis stalls, the result register holds and s_axis tready drops
//   once the input register is also full; nothing is lost or repeated.
//   After reset the block expects a new handshake, the hash registers are
//   zero and the length cap is 2^20. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_wire_handshake_deframer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input stream
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] rx_byte
  input  wire logic                          s_axis_tuser,  // [0] restart
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [pwhd_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [7:0] data,
                                                            // [27:8] payload_length,
                                                            // [29:28] error_code
  output logic [2:0]                         m_axis_tuser,  // [2:0] event_kind
  output logic                               m_axis_tlast,  // last
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pwhd_pkg::CFG_IW-1:0]   cfg_index_i,
  input  wire logic [pwhd_pkg::CFG_DW-1:0]   cfg_data_i
);
  import pwhd_pkg::*;

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_restart_q;
  logic              out_free;
  logic              advance;
  cfg_t              cfg;
  result_t           res_d;
  result_t           res_q;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
  end

  pwhd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  pwhd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .restart_i (in_restart_q),
    .cfg_i     (cfg),
    .res_o     (res_d)
  );

  pwhd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance),
    .res_i   (res_d),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_q)
  );

  // Result packing
  assign m_axis_tdata = {2'b00, res_q.error_code, res_q.payload_length, res_q.data};
  assign m_axis_tuser = res_q.event_kind;
  assign m_axis_tlast = res_q.last;

endmodule

`default_nettype wire

[dv/tb_peer_wire_handshake_deframer_core.sv]
// ----------------------------------------------------------------------------
// tb_peer_wire_handshake_deframer_core
// Self-checking bench for the peer wire deframer. Builds handshakes and
// length-prefixed messages, tracks the expected event stream with its own
// parser model and compares every result transfer field by field. Both
// stream sides idle and stall at random, and the result side holds off for
// a long stretch once so the input side fills up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_peer_wire_handshake_deframer_core;
  import pwhd_pkg::*;

  localparam logic [8*HS_TEXT_LEN-1:0] PROTO_TEXT  = "BitTorrent protocol";
  localparam int unsigned              HOLD_CYCLES = 200;

  // Clock, reset and block ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;  // [7:0] rx_byte
  logic                  s_axis_tuser  = 1'b0; // [0] restart
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;  // [7:0] data, [27:8] payload_length,
                                        // [29:28] error_code
  logic [2:0]            m_axis_tuser;  // [2:0] event_kind
  logic                  m_axis_tlast;  // last
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IW-1:0]     cfg_index_i   = '0;
  logic [CFG_DW-1:0]     cfg_data_i    = '0;

  // Parser model: configuration copy
  logic [HASH_W-1:0]     hash_cfg = '0;  // hash byte 0 in the top byte
  logic [CAP_W-1:0]      len_cap  = LENGTH_CEILING;

  // Parser model: state
  phase_e                parse_ph   = PH_HANDSHAKE;
  logic [POS_W-1:0]      byte_pos   = '0;
  logic [LEN_W-1:0]      len_acc    = '0;
  logic [PLEN_W-1:0]     pay_left   = '0;
  logic                  proto_bad  = 1'b0;
  logic                  hash_bad   = 1'b0;
  err_e                  sticky_err = ERR_NONE;

  // Expected events, oldest first
  result_t               expected_events[$];

  int unsigned           n_mismatch    = 0;
  int unsigned           n_results     = 0;
  int unsigned           bytes_sent    = 0;
  bit                    idle_on       = 1'b1;
  int unsigned           hold_req_cnt  = 0;
  int unsigned           hold_done_cnt = 0;
  int unsigned           hold_left     = 0;
  int unsigned           stall_left    = 0;

  peer_wire_handshake_deframer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [7:0] proto_byte(input int unsigned i);
    return PROTO_TEXT[8*(HS_TEXT_LEN-1-i) +: 8];
  endfunction

  function automatic logic [7:0] hash_byte(input int unsigned k);
    return hash_cfg[8*(HASH_BYTES-1-k) +: 8];
  endfunction

  // Advance the parser model by one input byte and return its event
  function automatic result_t parse_byte(input logic [7:0] b, input logic rs);
    result_t          r;
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] cap;
    r = '0;
    if (rs) begin
      parse_ph   = PH_HANDSHAKE;
      byte_pos   = '0;
      len_acc    = '0;
      pay_left   = '0;
      proto_bad  = 1'b0;
      hash_bad   = 1'b0;
      sticky_err = ERR_NONE;
      return r;
    end
    case (parse_ph)
      PH_HANDSHAKE: begin
        pos = byte_pos;
        if (pos == 0) begin
          if (b != 8'(HS_TEXT_LEN)) proto_bad = 1'b1;
        end else if (pos <= HS_TEXT_LEN) begin
          if (b != proto_byte(pos - 1)) proto_bad = 1'b1;
        end else if (pos >= HS_HASH_FIRST && pos < HS_PEER_FIRST) begin
          if (b != hash_byte(pos - HS_HASH_FIRST)) hash_bad = 1'b1;
        end
        if (pos == HS_LAST) begin
          // verdict on the final peer id byte; protocol error wins
          byte_pos = '0;
          if (proto_bad || hash_bad) begin
            sticky_err   = proto_bad ? ERR_PROTOCOL : ERR_HASH;
            parse_ph     = PH_ERROR;
            r.event_kind = EV_ERROR;
            r.error_code = sticky_err;
          end else begin
            parse_ph     = PH_LENGTH;
            len_acc      = '0;
            r.event_kind = EV_HS_OK;
            r.data       = b;
          end
        end else begin
          byte_pos = pos + POS_W'(1);
          if (pos >= HS_PEER_FIRST && !proto_bad && !hash_bad) begin
            r.event_kind = EV_PEER_ID;
            r.data       = b;
          end
        end
      end
      PH_LENGTH: begin
        len_acc = {len_acc[LEN_W-9:0], b};
        if (byte_pos[1:0] != 2'd3) begin
          byte_pos = POS_W'(byte_pos[1:0] + 2'd1);
        end else begin
          byte_pos = '0;
          cap      = LEN_W'(len_cap);
          if (cap > LEN_W'(LENGTH_CEILING)) cap = LEN_W'(LENGTH_CEILING);
          if (len_acc == 0) begin
            r.event_kind = EV_KEEPALIVE;
          end else if (len_acc > cap) begin
            sticky_err   = ERR_OVERSIZE;
            parse_ph     = PH_ERROR;
            r.event_kind = EV_ERROR;
            r.error_code = ERR_OVERSIZE;
          end else begin
            pay_left = PLEN_W'(len_acc - 1);
            parse_ph = PH_ID;
          end
          len_acc = '0;
        end
      end
      PH_ID: begin
        r.event_kind = EV_MSG_ID;
        r.data       = b;
        if (pay_left == 0) begin
          parse_ph = PH_LENGTH;
          r.last   = 1'b1;
        end else begin
          parse_ph         = PH_PAYLOAD;
          r.payload_length = pay_left;
        end
      end
      PH_PAYLOAD: begin
        if (pay_left != 0) pay_left = pay_left - PLEN_W'(1);
        r.event_kind = EV_PAYLOAD;
        r.data       = b;
        if (pay_left == 0) begin
          parse_ph = PH_LENGTH;
          byte_pos = '0;
          r.last   = 1'b1;
        end
      end
      default: begin
        parse_ph     = PH_ERROR;
        r.event_kind = EV_ERROR;
        r.error_code = sticky_err;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    n_mismatch++;
    $display("[%0t] result %0d: %s", $time, n_results, what);
  endtask

  // Compare one result transfer with the oldest expected event
  task automatic check_result();
    result_t want;
    n_results++;
    if (expected_events.size() == 0) begin
      report_mismatch($sformatf("unexpected result, kind %0d", m_axis_tuser));
      return;
    end
    want = expected_events.pop_front();
    if (m_axis_tuser != want.event_kind)
      report_mismatch($sformatf("event_kind got %0d want %0d", m_axis_tuser,
                                want.event_kind));
    if (m_axis_tdata[7:0] != want.data)
      report_mismatch($sformatf("data got %02h want %02h", m_axis_tdata[7:0], want.data));
    if (m_axis_tdata[27:8] != want.payload_length)
      report_mismatch($sformatf("payload_length got %0h want %0h", m_axis_tdata[27:8],
                                want.payload_length));
    if (m_axis_tlast != want.last)
      report_mismatch($sformatf("last got %0b want %0b", m_axis_tlast, want.last));
    if (m_axis_tdata[29:28] != want.error_code)
      report_mismatch($sformatf("error_code got %0d want %0d", m_axis_tdata[29:28],
                                want.error_code));
  endtask

  // Result side: check each transfer, then pick the next ready value
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    if (hold_req_cnt != hold_done_cnt) begin
      hold_done_cnt = hold_req_cnt;
      hold_left     = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // One input transfer, sometimes with a random gap in front of it
  task automatic send_byte(input logic [7:0] b, input logic rs);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= rs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_events.push_back(parse_byte(b, rs));
    bytes_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
  endtask

  // Write all four registers back to back once the block is idle
  task automatic load_config(input logic [HASH_W-1:0] hash, input logic [CAP_W-1:0] cap);
    cfg_idx_e    idx;
    logic [63:0] val;
    drain_results();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CFG_HASH_HIGH: val = hash[159:96];
        CFG_HASH_MID:  val = hash[95:32];
        CFG_HASH_LOW:  val = {32'h0, hash[31:0]};
        default:       val = 64'(cap);
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    hash_cfg = hash;
    len_cap  = cap;
  endtask

  task automatic send_restart();
    send_byte(8'($urandom), 1'b1);
  endtask

  // 68-byte handshake, optionally with a corrupted protocol byte, hash byte or both
  task automatic send_handshake(input bit bad_proto, input bit bad_hash);
    logic [7:0]  hs [0:HS_LAST];
    int unsigned k;
    for (k = 0; k <= HS_LAST; k++) hs[k] = 8'($urandom);
    hs[0] = 8'(HS_TEXT_LEN);
    for (k = 1; k <= HS_TEXT_LEN; k++) hs[k] = proto_byte(k - 1);
    for (k = 0; k < HASH_BYTES; k++) hs[HS_HASH_FIRST + k] = hash_byte(k);
    if (bad_proto) begin
      k = $urandom_range(0, HS_TEXT_LEN);
      hs[k] = hs[k] ^ 8'($urandom_range(1, 255));
    end
    if (bad_hash) begin
      k = $urandom_range(HS_HASH_FIRST, HS_PEER_FIRST - 1);
      hs[k] = hs[k] ^ 8'($urandom_range(1, 255));
    end
    for (k = 0; k <= HS_LAST; k++) send_byte(hs[k], 1'b0);
  endtask

  task automatic send_length(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8], 1'b0);
  endtask

  // Length prefix, id byte and payload, all random content
  task automatic send_message(input logic [31:0] len);
    send_length(len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom), 1'b0);
  endtask

  task automatic send_noise(input int unsigned n);
    repeat (n) send_byte(8'($urandom), 1'b0);
  endtask

  // One connection: restart, handshake (a bad one is followed only by noise),
  // then messages that may end in an oversize error, a cut-off message or noise
  task automatic run_session();
    int unsigned roll;
    int unsigned n;
    logic [31:0] cap_eff;
    logic [31:0] len;
    send_restart();
    roll = $urandom_range(0, 15);
    send_handshake(roll == 0 || roll == 2, roll == 1 || roll == 2);
    if (roll <= 2) begin
      send_noise($urandom_range(1, 4));
      return;
    end
    cap_eff = 32'(len_cap);
    if (cap_eff > 32'(LENGTH_CEILING)) cap_eff = 32'(LENGTH_CEILING);
    n = $urandom_range(1, 10);
    repeat (n) begin
      roll = $urandom_range(0, 31);
      if (roll < 3) begin
        send_length(32'h0);
      end else if (roll == 3 || cap_eff == 0) begin
        case ($urandom_range(0, 2))
          0:       len = cap_eff + 1;
          1:       len = 32'($urandom) | 32'h8000_0000;
          default: len = cap_eff + $urandom_range(2, 1000);
        endcase
        send_length(len);
        send_noise($urandom_range(1, 3));
        return;
      end else if (roll == 4) begin
        // cut off after a length prefix, often inside its message; next session restarts
        send_length($urandom_range(1, cap_eff < 20 ? cap_eff : 20));
        send_noise($urandom_range(0, 4));
        return;
      end else if (roll == 5) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), $urandom_range(0, 3) == 0);
        return;
      end else if (roll == 6) begin
        send_message($urandom_range(1, cap_eff < 300 ? cap_eff : 300));
      end else begin
        send_message($urandom_range(1, cap_eff < 12 ? cap_eff : 12));
      end
    end
  endtask

  function automatic logic [HASH_W-1:0] random_hash();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Reset defaults: zero hash, 2^20 cap; every event kind and error code
  task automatic test_reset_defaults();
    send_handshake(1'b0, 1'b0);
    send_length(32'h0);
    send_message(32'd1);
    send_message(32'd3);
    send_length(32'h0010_0001);
    send_noise(2);
    send_restart();
    send_handshake(1'b1, 1'b1);
    send_noise(2);
    send_restart();
    send_handshake(1'b0, 1'b1);
    send_noise(1);
    send_restart();
    send_noise(10);
    send_restart();
    send_handshake(1'b0, 1'b0);
    send_message(32'd2);
  endtask

  // Length cap at zero, one and above the ceiling; all-ones hash
  task automatic test_cap_extremes();
    load_config({HASH_W{1'b1}}, 21'd0);
    send_restart();
    send_handshake(1'b0, 1'b0);
    send_length(32'h0);
    send_length(32'h1);
    send_noise(1);
    load_config(random_hash(), 21'd1);
    send_restart();
    send_handshake(1'b0, 1'b0);
    send_message(32'd1);
    send_length(32'd2);
    send_noise(1);
    load_config(random_hash(), {CAP_W{1'b1}});
    send_restart();
    send_handshake(1'b0, 1'b0);
    // largest legal length: id carries the widest payload count
    send_length(32'h0010_0000);
    send_noise(4);
    send_restart();
    send_handshake(1'b0, 1'b0);
    send_length(32'h0010_0001);
    send_noise(1);
    load_config('0, LENGTH_CEILING);
    send_restart();
    send_handshake(1'b0, 1'b0);
    send_length(32'hFFFF_FFFF);
    send_noise(1);
  endtask

  // Random sessions under a rotating set of configurations
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned      stop_at;
    int unsigned      p;
    logic [HASH_W-1:0] hash;
    logic [CAP_W-1:0]  cap;
    stop_at = bytes_sent + n_bytes;
    p = 0;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 3))
        0:       hash = '0;
        1:       hash = {HASH_W{1'b1}};
        default: hash = random_hash();
      endcase
      case (p % 6)
        0:       cap = CAP_W'($urandom_range(1, 16));
        1:       cap = 21'd1;
        2:       cap = LENGTH_CEILING;
        3:       cap = {CAP_W{1'b1}};
        4:       cap = CAP_W'($urandom_range(17, 400));
        default: cap = 21'd0;
      endcase
      load_config(hash, cap);
      repeat (4) if (bytes_sent < stop_at) run_session();
      p++;
    end
  endtask

  // Result side holds off while the input keeps offering bytes
  task automatic test_backpressure();
    load_config(random_hash(), 21'd64);
    hold_req_cnt++;
    repeat (3) run_session();
  endtask

  // Last part: no gaps or stalls on either side
  task automatic test_steady_stream();
    drain_results();
    idle_on = 1'b0;
    load_config(random_hash(), 21'd24);
    repeat (3) run_session();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_cap_extremes();
    test_random_traffic(400);
    test_backpressure();
    test_steady_stream();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("peer_wire_handshake_deframer_core: match");
    end else begin
      $display("peer_wire_handshake_deframer_core: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("peer_wire_handshake_deframer_core: mismatch");
    $finish;
  end

endmodule

[files.f]
rtl/pwhd_pkg.sv
rtl/pwhd_cfg_regs.sv
rtl/pwhd_parser.sv
rtl/pwhd_out_reg.sv
rtl/peer_wire_handshake_deframer_core.sv
dv/tb_peer_wire_handshake_deframer_core.sv
